// File: rtl/arq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_pkg
// shared types and codes for the arq message tables unit
// ----------------------------------------------------------------------------
package arq_pkg;

  localparam int unsigned EventW = 4;
  localparam int unsigned CharW  = 8;
  localparam int unsigned OutIdW = 16;
  localparam int unsigned StampW = 16;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned FidW   = 16;

  localparam logic [1:0] ModeSend = 2'd0;
  localparam logic [1:0] ModeRecv = 2'd1;
  localparam logic [1:0] ModeTick = 2'd2;
  localparam logic [1:0] ModeRead = 2'd3;

  localparam logic [EventW-1:0] EvSent      = 4'd0;
  localparam logic [EventW-1:0] EvSendFull  = 4'd1;
  localparam logic [EventW-1:0] EvAckFreed  = 4'd2;
  localparam logic [EventW-1:0] EvAckNone   = 4'd3;
  localparam logic [EventW-1:0] EvStored    = 4'd4;
  localparam logic [EventW-1:0] EvDuplicate = 4'd5;
  localparam logic [EventW-1:0] EvRecvFull  = 4'd6;
  localparam logic [EventW-1:0] EvResent    = 4'd7;
  localparam logic [EventW-1:0] EvIdle      = 4'd8;
  localparam logic [EventW-1:0] EvDelivered = 4'd9;
  localparam logic [EventW-1:0] EvEmpty     = 4'd10;

  // command from controller to datapath
  typedef struct packed {
    logic       scan;    // register item and run table scans
    logic       commit;  // apply update and form result
  } ctrl_t;

endpackage

// File: rtl/arq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_datapath
// table storage, parallel match and priority encode, result formation
// ----------------------------------------------------------------------------
module arq_datapath #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  arq_pkg::ctrl_t                ctrl_i,
  input  logic [1:0]                    mode_i,
  input  logic [arq_pkg::CharW-1:0]     msg_char_i,
  input  logic                          frame_is_ack_i,
  input  logic [arq_pkg::FidW-1:0]      frame_id_i,
  input  logic [arq_pkg::CfgW-1:0]      timeout_i,
  output logic [arq_pkg::EventW-1:0]    event_res_o,
  output logic [arq_pkg::OutIdW-1:0]    out_id_o,
  output logic [arq_pkg::CharW-1:0]     out_char_o,
  output logic                          send_ack_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [TABLE_DEPTH-1:0]   u_vld_q, r_vld_q;
  logic [ID_BITS-1:0]       u_id_q [TABLE_DEPTH];
  logic [arq_pkg::CharW-1:0]  u_ch_q [TABLE_DEPTH];
  logic [arq_pkg::StampW-1:0] u_st_q [TABLE_DEPTH];
  logic [ID_BITS-1:0]       r_id_q [TABLE_DEPTH];
  logic [arq_pkg::CharW-1:0]  r_ch_q [TABLE_DEPTH];
  logic [ID_BITS-1:0]       next_id_q;
  logic [arq_pkg::StampW-1:0] now_q;

  // item registers
  logic [1:0]               mode_q;
  logic [arq_pkg::CharW-1:0] ch_q;
  logic                     ack_q;
  logic [ID_BITS-1:0]       fid_q;
  logic [arq_pkg::FidW-1:0] fid_ext;

  // scan results
  logic                     hit_q;
  logic [IdxW-1:0]          idx_q;
  logic                     dup_q;
  logic                     hit_d, dup_d;
  logic [IdxW-1:0]          idx_d;
  logic [arq_pkg::StampW-1:0] now_inc;
  logic [ID_BITS-1:0]       fid_m;

  if (ID_BITS >= arq_pkg::FidW) begin : g_wide
    assign fid_m = ID_BITS'(frame_id_i);
  end else begin : g_narrow
    assign fid_m = frame_id_i[ID_BITS-1:0];
  end

  assign now_inc = now_q + 1'b1;

  // scan runs against the item just latched
  always_comb begin
    logic [TABLE_DEPTH-1:0] cand;
    logic [TABLE_DEPTH-1:0] dupv;
    logic [arq_pkg::StampW-1:0] age;
    cand  = '0;
    dupv  = '0;
    hit_d = 1'b0;
    dup_d = 1'b0;
    idx_d = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      age = now_inc - u_st_q[i];
      case (mode_q)
        arq_pkg::ModeSend: cand[i] = !u_vld_q[i];
        arq_pkg::ModeRecv: begin
          if (ack_q) begin
            cand[i] = u_vld_q[i] && (u_id_q[i] == fid_q);
          end else begin
            cand[i] = !r_vld_q[i];
          end
          dupv[i] = r_vld_q[i] && (r_id_q[i] == fid_q);
        end
        arq_pkg::ModeTick: cand[i] = u_vld_q[i] && (age > {8'd0, timeout_i});
        default:           cand[i] = r_vld_q[i];
      endcase
    end
    dup_d = |dupv && !ack_q;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_d = 1'b1;
        idx_d = IdxW'(i);
      end
    end
  end

  assign fid_ext = arq_pkg::FidW'(fid_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan) begin
      mode_q <= mode_i;
      ch_q   <= msg_char_i;
      ack_q  <= frame_is_ack_i;
      fid_q  <= fid_m;
    end
    hit_q <= hit_d;
    dup_q <= dup_d;
    idx_q <= idx_d;
  end

  // hit/idx are registered at the end of the scan state, before the controller commits

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_vld_q     <= '0;
      r_vld_q     <= '0;
      next_id_q   <= '0;
      now_q       <= '0;
      event_res_o <= '0;
      out_id_o    <= '0;
      out_char_o  <= '0;
      send_ack_o  <= 1'b0;
    end else if (ctrl_i.commit) begin
      out_id_o   <= '0;
      out_char_o <= '0;
      send_ack_o <= 1'b0;
      case (mode_q)
        arq_pkg::ModeSend: begin
          if (hit_q) begin
            u_vld_q[idx_q] <= 1'b1;
            next_id_q      <= next_id_q + 1'b1;
            event_res_o    <= arq_pkg::EvSent;
            out_id_o       <= arq_pkg::OutIdW'(next_id_q);
            out_char_o     <= ch_q;
          end else begin
            event_res_o <= arq_pkg::EvSendFull;
          end
        end
        arq_pkg::ModeRecv: begin
          out_id_o <= fid_ext;
          if (ack_q) begin
            if (hit_q) u_vld_q[idx_q] <= 1'b0;
            event_res_o <= hit_q ? arq_pkg::EvAckFreed : arq_pkg::EvAckNone;
          end else if (dup_q) begin
            event_res_o <= arq_pkg::EvDuplicate;
            send_ack_o  <= 1'b1;
          end else if (hit_q) begin
            r_vld_q[idx_q] <= 1'b1;
            event_res_o    <= arq_pkg::EvStored;
            send_ack_o     <= 1'b1;
          end else begin
            event_res_o <= arq_pkg::EvRecvFull;
          end
        end
        arq_pkg::ModeTick: begin
          now_q <= now_inc;
          if (hit_q) begin
            event_res_o <= arq_pkg::EvResent;
            out_id_o    <= arq_pkg::OutIdW'(u_id_q[idx_q]);
            out_char_o  <= u_ch_q[idx_q];
          end else begin
            event_res_o <= arq_pkg::EvIdle;
          end
        end
        default: begin
          if (hit_q) begin
            r_vld_q[idx_q] <= 1'b0;
            event_res_o    <= arq_pkg::EvDelivered;
            out_id_o       <= arq_pkg::OutIdW'(r_id_q[idx_q]);
            out_char_o     <= r_ch_q[idx_q];
          end else begin
            event_res_o <= arq_pkg::EvEmpty;
          end
        end
      endcase
    end
  end

  // entry payload, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && hit_q) begin
      case (mode_q)
        arq_pkg::ModeSend: begin
          u_id_q[idx_q] <= next_id_q;
          u_ch_q[idx_q] <= ch_q;
          u_st_q[idx_q] <= now_q;
        end
        arq_pkg::ModeRecv: begin
          if (!ack_q && !dup_q) begin
            r_id_q[idx_q] <= fid_q;
            r_ch_q[idx_q] <= ch_q;
          end
        end
        arq_pkg::ModeTick: u_st_q[idx_q] <= now_inc;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/arq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_ctrl
// sequencer: latch item, scan tables, commit and strobe result
// ----------------------------------------------------------------------------
module arq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output arq_pkg::ctrl_t ctrl_o
);

  typedef enum logic [1:0] {StIdle, StScan, StCommit} state_e;

  state_e state_q;

  assign ctrl_o.scan   = start && (state_q == StIdle);
  assign ctrl_o.commit = (state_q == StCommit);
  assign busy          = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state_q)
        StIdle:   if (start) state_q <= StScan;
        StScan:   state_q <= StCommit;
        StCommit: begin
          state_q <= StIdle;
          done    <= 1'b1;
        end
        default:  state_q <= StIdle;
      endcase
    end
  end

endmodule

// File: rtl/arq_message_tables_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_message_tables_unit
// arq send/receive tables with retransmit scan
// ----------------------------------------------------------------------------
// channel   handshake            payload
// item in   start & !busy        mode_i msg_char_i frame_is_ack_i frame_id_i
// result    done (one cycle)     event_res_o out_id_o out_char_o send_ack_o
// config    cfg_valid & cfg_ready cfg_data_i (timeout_intervals)
//
// an item passes through latch, registered table scan (parallel compare and
// priority encode) and commit; done shows in the cycle after commit, and the
// next item can be taken at the edge that takes the result, so items do not
// overlap.
// reset clears valid bits, next id, time and sets timeout to 2.
// results cannot be stalled; cfg_ready is high whenever no item is in work.
// ----------------------------------------------------------------------------
module arq_message_tables_unit #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  msg_char_i,
  input  logic        frame_is_ack_i,
  input  logic [15:0] frame_id_i,
  output logic        done,
  output logic [3:0]  event_res_o,
  output logic [15:0] out_id_o,
  output logic [7:0]  out_char_o,
  output logic        send_ack_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data_i
);

  arq_pkg::ctrl_t ctrl;
  logic [7:0]     timeout_q;

  assign cfg_ready = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) timeout_q <= 8'd2;
    else if (cfg_valid && cfg_ready) timeout_q <= cfg_data_i;
  end

  arq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .done, .ctrl_o(ctrl)
  );

  arq_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .ID_BITS(ID_BITS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .mode_i, .msg_char_i, .frame_is_ack_i,
    .frame_id_i, .timeout_i(timeout_q), .event_res_o, .out_id_o, .out_char_o,
    .send_ack_o
  );

endmodule

// File: rtl/arq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_checker
// port-level checks on the arq message tables unit
// ----------------------------------------------------------------------------
module arq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [3:0] event_res_o,
  input logic       send_ack_o
);

  // accepted item gives a result
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##3 done) else $error("missing result");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised");

  a_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && send_ack_o |-> (event_res_o == arq_pkg::EvStored ||
                            event_res_o == arq_pkg::EvDuplicate))
    else $error("ack on wrong event");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> event_res_o <= arq_pkg::EvEmpty) else $error("bad event");

endmodule

bind arq_message_tables_unit arq_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done, .event_res_o, .send_ack_o
);
